// ----- hdl/tpu_pkg.sv -----
// ----------------------------------------------------------------------------
// tpu_pkg
// Shared types and constants of the pattern unpacker.
// ----------------------------------------------------------------------------
package tpu_pkg;

  localparam int MAX_ROWS     = 256;
  localparam int MAX_CHANNELS = 32;

  // Configuration register indexes
  localparam logic CFG_ROWS     = 1'b0;
  localparam logic CFG_CHANNELS = 1'b1;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_DONE  = 2'd1;
  localparam logic [1:0] STAT_TRUNC = 2'd2;

  // Lead byte decoding
  localparam logic [7:0] LEAD_MASK_FLAG = 8'h80;
  localparam logic [4:0] FIELD_BITS     = 5'h1F;
  localparam logic [4:0] FULL_CELL_REST = 5'h1E;  // all fields after the note

  // Parser state; pending == 0 means the next byte is a lead byte unless finished is set
  typedef struct packed {
    logic [4:0]      pending;
    logic [7:0]      lead;
    logic [4:0][7:0] fields;   // note, instrument, volume, effect type, param
    logic [7:0]      row;
    logic [4:0]      chan;
    logic            finished;
  } parse_state_t;

  typedef struct packed {
    logic [7:0]      cell_mask;
    logic [4:0][7:0] fields;
    logic [7:0]      row_index;
    logic [4:0]      channel_index;
    logic            cell_valid;
    logic [1:0]      status;
  } cell_t;

endpackage

// ----- hdl/tpu_if.sv -----
// ----------------------------------------------------------------------------
// tpu_if
// Valid/ready channels for packed bytes in and decoded cells out.
// ----------------------------------------------------------------------------
interface tpu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source (output valid, data_byte, end_of_data, input ready);
  modport sink   (input valid, data_byte, end_of_data, output ready);
endinterface

interface tpu_cell_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_mask;
  logic [7:0] note_value;
  logic [7:0] instrument_number;
  logic [7:0] volume_byte;
  logic [7:0] effect_kind;
  logic [7:0] effect_value;
  logic [7:0] row_index;
  logic [4:0] channel_index;
  logic       cell_valid;
  logic [1:0] status;

  modport source (output valid, cell_mask, note_value, instrument_number, volume_byte,
                  effect_kind, effect_value, row_index, channel_index, cell_valid,
                  status, input ready);
  modport sink   (input valid, cell_mask, note_value, instrument_number, volume_byte,
                  effect_kind, effect_value, row_index, channel_index, cell_valid,
                  status, output ready);
endinterface

// ----- hdl/tracker_pattern_unpacker_top.sv -----
// ----------------------------------------------------------------------------
// tracker_pattern_unpacker_top
// Byte-serial unpacker for packed tracker pattern data.
// ----------------------------------------------------------------------------
// Usage:
//   feed  : packed pattern bytes, one per transfer; end_of_data marks the
//           last byte of a pattern's data.
//   cells : decoded cells, at most one per input transfer. A byte that
//           completes a cell yields a cell; a pattern cut off mid-cell yields
//           one transfer with cell_valid low and status TRUNC.
//   cfg_* : plain write port. Index 0 sets rows per pattern, index 1 sets
//           channels per row. Write only while no byte is in flight.
// Output: a result is registered and shows on cells the cycle after its byte.
// Throughput: one byte per cycle unless cells stalls; the next parser state
//   is combinational; the one-entry result register decouples the two sides.
// Stall: while a result waits on cells, feed stays ready only if that
//   result is taken in the same cycle; otherwise input waits.
// Reset: rst (synchronous) restores 64 rows, 8 channels and restarts the
//   parser at row 0, channel 0, expecting a lead byte.
// ----------------------------------------------------------------------------
module tracker_pattern_unpacker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data,
  tpu_byte_if.sink    feed,
  tpu_cell_if.source  cells
);
  import tpu_pkg::*;

  // Configuration registers
  logic [8:0] rows_cfg;
  logic [5:0] chans_cfg;
  logic [8:0] rows_eff;
  logic [5:0] chans_eff;

  // Parser state and result register
  parse_state_t st;
  parse_state_t st_next;
  logic         emit;
  cell_t        cell_next;
  cell_t        cell_q;
  logic         out_valid;
  logic         accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg  <= 9'd64;
      chans_cfg <= 6'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS:     rows_cfg  <= cfg_data;
        CFG_CHANNELS: chans_cfg <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Clamp out-of-range settings: zero acts as one, above max acts as max
  always_comb begin
    if (rows_cfg == 9'd0) begin
      rows_eff = 9'd1;
    end else if (rows_cfg > 9'(MAX_ROWS)) begin
      rows_eff = 9'(MAX_ROWS);
    end else begin
      rows_eff = rows_cfg;
    end
    if (chans_cfg == 6'd0) begin
      chans_eff = 6'd1;
    end else if (chans_cfg > 6'(MAX_CHANNELS)) begin
      chans_eff = 6'(MAX_CHANNELS);
    end else begin
      chans_eff = chans_cfg;
    end
  end

  tpu_cell_decoder u_decoder (
    .st          (st),
    .data_byte   (feed.data_byte),
    .end_of_data (feed.end_of_data),
    .rows_eff    (rows_eff),
    .chans_eff   (chans_eff),
    .st_next     (st_next),
    .emit        (emit),
    .cell_out    (cell_next)
  );

  // Take a byte whenever the result slot is free or being drained
  assign feed.ready = !out_valid || cells.ready;
  assign accept     = feed.valid && feed.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) st <= st_next;
      // a new result refills the slot even while the old one drains
      if (accept && emit) begin
        out_valid <= 1'b1;
      end else if (cells.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) cell_q <= cell_next;
  end

  assign cells.valid             = out_valid;
  assign cells.cell_mask         = cell_q.cell_mask;
  assign cells.note_value        = cell_q.fields[0];
  assign cells.instrument_number = cell_q.fields[1];
  assign cells.volume_byte       = cell_q.fields[2];
  assign cells.effect_kind       = cell_q.fields[3];
  assign cells.effect_value      = cell_q.fields[4];
  assign cells.row_index         = cell_q.row_index;
  assign cells.channel_index     = cell_q.channel_index;
  assign cells.cell_valid        = cell_q.cell_valid;
  assign cells.status            = cell_q.status;

  // A finished pattern never holds a half-parsed cell
  a_finished_idle: assert property (@(posedge clk) disable iff (rst)
    st.finished |-> st.pending == 5'd0)
    else $error("finished pattern with pending fields");

  // An ok or done status always carries a completed cell
  a_ok_has_cell: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (cell_q.status == STAT_OK || cell_q.status == STAT_DONE))
      |-> cell_q.cell_valid)
    else $error("status without a completed cell");

  // A truncation report carries empty cell fields
  a_trunc_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !cell_q.cell_valid)
      |-> (cell_q.status == STAT_TRUNC && cell_q.cell_mask == 8'd0 && cell_q.fields == '0))
    else $error("malformed truncation report");

  // End of data always leaves the parser restarted
  a_eod_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && feed.end_of_data) |=> (st == parse_state_t'('0)))
    else $error("parser not restarted after end of data");

endmodule

// ----- hdl/tpu_cell_decoder.sv -----
// ----------------------------------------------------------------------------
// tpu_cell_decoder
// Next parser state and result cell for one packed byte.
// ----------------------------------------------------------------------------
module tpu_cell_decoder (
  input  tpu_pkg::parse_state_t st,
  input  logic [7:0]            data_byte,
  input  logic                  end_of_data,
  input  logic [8:0]            rows_eff,
  input  logic [5:0]            chans_eff,
  output tpu_pkg::parse_state_t st_next,
  output logic                  emit,
  output tpu_pkg::cell_t        cell_out
);
  import tpu_pkg::*;

  parse_state_t work;
  logic [4:0]   sel;
  logic         chan_wrap;
  logic         row_last;

  always_comb begin
    work      = st;
    st_next   = st;
    emit      = 1'b0;
    cell_out  = '0;
    sel       = 5'd0;
    chan_wrap = 1'b0;
    row_last  = 1'b0;

    if (st.finished) begin
      // swallow bytes until the end marker
      if (end_of_data) begin
        st_next = '0;
      end
    end else begin
      if (st.pending == 5'd0) begin
        work.fields = '0;
        work.lead   = data_byte;
        if ((data_byte & LEAD_MASK_FLAG) != 8'd0) begin
          work.pending = data_byte[4:0] & FIELD_BITS;
        end else begin
          work.fields[0] = data_byte;
          work.pending   = FULL_CELL_REST;
        end
      end else begin
        // lowest pending field takes this byte
        sel = st.pending & (~st.pending + 5'd1);
        for (int k = 0; k < 5; k++) begin
          if (sel[k]) work.fields[k] = data_byte;
        end
        work.pending = st.pending & ~sel;
      end

      if (work.pending == 5'd0) begin
        emit                   = 1'b1;
        cell_out.cell_mask     = work.lead;
        cell_out.fields        = work.fields;
        cell_out.row_index     = st.row;
        cell_out.channel_index = st.chan;
        cell_out.cell_valid    = 1'b1;
        chan_wrap = ({1'b0, st.chan} + 6'd1) >= chans_eff;
        row_last  = ({1'b0, st.row} + 9'd1) >= rows_eff;
        if (chan_wrap) begin
          work.chan = 5'd0;
          if (row_last) begin
            work.finished = 1'b1;
          end else begin
            work.row = st.row + 8'd1;
          end
        end else begin
          work.chan = st.chan + 5'd1;
        end
        if (work.finished) begin
          cell_out.status = STAT_DONE;
        end else if (end_of_data) begin
          cell_out.status = STAT_TRUNC;
        end else begin
          cell_out.status = STAT_OK;
        end
        st_next = end_of_data ? parse_state_t'('0) : work;
      end else if (end_of_data) begin
        // data ran out mid-cell: report the position only
        emit                   = 1'b1;
        cell_out.row_index     = st.row;
        cell_out.channel_index = st.chan;
        cell_out.cell_valid    = 1'b0;
        cell_out.status        = STAT_TRUNC;
        st_next                = '0;
      end else begin
        st_next = work;
      end
    end
  end

endmodule
